@@ design/park_transform_defines.svh @@
// ----------------------------------------------------------------------------
// park_transform_defines
// Assertion macros shared by the park transform modules.
// ----------------------------------------------------------------------------
`ifndef PARK_TRANSFORM_DEFINES_SVH
`define PARK_TRANSFORM_DEFINES_SVH

// same-cycle implication
`define PT_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pt_pkg.sv @@
// ----------------------------------------------------------------------------
// pt_pkg
// Constants for the CORDIC park transform.
// ----------------------------------------------------------------------------
package pt_pkg;

    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int ANGLE_WIDTH_DEF     = 16;
    localparam int ROTATION_STAGES_DEF = 16;

    localparam int GUARD_BITS = 8;
    localparam int MAX_STAGES = 24;
    localparam int ANGLE_BITS = 32;

    localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

    // 1/K as Q0.32, split in halves
    localparam logic [15:0] INV_GAIN_HI = 16'h9B74;
    localparam logic [15:0] INV_GAIN_LO = 16'hEDA8;

    // atan(2^-i) in fractions of a turn, 2^32 = full turn
    localparam logic [31:0] ATAN_TURNS [MAX_STAGES] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

endpackage

@@ design/pt_prerot.sv @@
// ----------------------------------------------------------------------------
// pt_prerot
// Quadrant pre-rotation: folds the negated angle into +/- an eighth turn.
// ----------------------------------------------------------------------------
`include "park_transform_defines.svh"

module pt_prerot
    import pt_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] alpha,
    input  logic signed [SAMPLE_WIDTH-1:0] beta,
    input  logic        [ANGLE_WIDTH-1:0]  angle,
    output logic                           out_valid,
    output logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] x_out,
    output logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] y_out,
    output logic signed [ANGLE_BITS-1:0]   z_out
);

    localparam int DW = SAMPLE_WIDTH + GUARD_BITS + 3;
    localparam int AS = ANGLE_BITS - ANGLE_WIDTH;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic signed [DW-1:0]         x0;
    logic signed [DW-1:0]         y0;
    logic        [ANGLE_BITS-1:0] phi;
    logic        [ANGLE_BITS-1:0] phi_bias;
    logic        [1:0]            quad;
    logic signed [DW-1:0]         x_next;
    logic signed [DW-1:0]         y_next;
    logic signed [ANGLE_BITS-1:0] z_next;
    logic                         valid_reg;
    logic signed [DW-1:0]         x_reg;
    logic signed [DW-1:0]         y_reg;
    logic signed [ANGLE_BITS-1:0] z_reg;

    always_comb
    begin
        x0       = {{3{alpha[SAMPLE_WIDTH-1]}}, alpha, {GUARD_BITS{1'b0}}};
        y0       = {{3{beta[SAMPLE_WIDTH-1]}},  beta,  {GUARD_BITS{1'b0}}};
        phi      = {ANGLE_BITS{1'b0}} - {angle, {AS{1'b0}}};
        phi_bias = phi + EIGHTH_TURN;
        quad     = phi_bias[ANGLE_BITS-1:ANGLE_BITS-2];
        z_next   = signed'(phi - {quad, {(ANGLE_BITS-2){1'b0}}});
        case (quad)
            QUAD_0:
            begin
                x_next = x0;
                y_next = y0;
            end
            QUAD_1:
            begin
                x_next = -y0;
                y_next = x0;
            end
            QUAD_2:
            begin
                x_next = -x0;
                y_next = -y0;
            end
            QUAD_3:
            begin
                x_next = y0;
                y_next = -x0;
            end
            default:
            begin
                x_next = x0;
                y_next = y0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

    // residual stays within one eighth of a turn
    `PT_ASSERT_IMPL(a_residual_range, clk, rst_n, valid_reg, (z_reg <= signed'(EIGHTH_TURN)) && (z_reg >= -signed'(EIGHTH_TURN)), "pre-rotation residual out of range")

endmodule

@@ design/pt_cell.sv @@
// ----------------------------------------------------------------------------
// pt_cell
// One CORDIC micro-rotation stage, registered.
// ----------------------------------------------------------------------------
`include "park_transform_defines.svh"

module pt_cell
    import pt_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int STAGE        = 0
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] x_in,
    input  logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] y_in,
    input  logic signed [ANGLE_BITS-1:0]              z_in,
    output logic                                      out_valid,
    output logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] x_out,
    output logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] y_out,
    output logic signed [ANGLE_BITS-1:0]              z_out
);

    localparam int DW = SAMPLE_WIDTH + GUARD_BITS + 3;
    localparam logic signed [ANGLE_BITS-1:0] ATAN = ATAN_TURNS[STAGE];

    logic signed [DW-1:0]         dx;
    logic signed [DW-1:0]         dy;
    logic signed [DW-1:0]         x_next;
    logic signed [DW-1:0]         y_next;
    logic signed [ANGLE_BITS-1:0] z_next;
    logic                         valid_reg;
    logic signed [DW-1:0]         x_reg;
    logic signed [DW-1:0]         y_reg;
    logic signed [ANGLE_BITS-1:0] z_reg;

    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (!z_in[ANGLE_BITS-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

    `PT_ASSERT_NEXT(a_valid_moves, clk, rst_n, in_valid, valid_reg, "word lost in rotation chain")
    `PT_ASSERT_NEXT(a_no_ghost, clk, rst_n, !in_valid, !valid_reg, "spurious word in rotation chain")

endmodule

@@ design/pt_gain.sv @@
// ----------------------------------------------------------------------------
// pt_gain
// CORDIC gain correction with rounding and saturation, two stages.
// ----------------------------------------------------------------------------
`include "park_transform_defines.svh"

module pt_gain
    import pt_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] x_in,
    input  logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] y_in,
    output logic                                      out_valid,
    output logic signed [SAMPLE_WIDTH:0]              d_out,
    output logic signed [SAMPLE_WIDTH:0]              q_out
);

    localparam int DW = SAMPLE_WIDTH + GUARD_BITS + 3;
    localparam int PW = DW + 16;
    localparam int SW = PW + 1;
    localparam int RS = 16 + GUARD_BITS;
    localparam logic [SW-1:0] ROUND = SW'(1) << (RS - 1);
    localparam logic [SW-RS-1:0] LIM = (SW-RS)'((1 << SAMPLE_WIDTH) - 1);

    logic signed [DW-1:0]           lane_in   [2];
    logic        [DW-1:0]           mag       [2];
    logic        [PW-1:0]           prod_hi   [2];
    logic        [PW-1:0]           prod_lo   [2];
    logic        [SW-1:0]           total     [2];
    logic        [SW-RS-1:0]        rounded   [2];
    logic        [SAMPLE_WIDTH-1:0] clipped   [2];
    logic signed [SAMPLE_WIDTH:0]   res_next  [2];
    logic        [PW-1:0]           hi_reg    [2];
    logic        [DW-1:0]           lo_reg    [2];
    logic        [1:0]              neg_reg;
    logic                           mid_valid_reg;
    logic                           valid_reg;
    logic signed [SAMPLE_WIDTH:0]   d_reg;
    logic signed [SAMPLE_WIDTH:0]   q_reg;

    always_comb
    begin
        lane_in[0] = x_in;
        lane_in[1] = y_in;
        for (int k = 0; k < 2; k++)
        begin
            mag[k]      = lane_in[k][DW-1] ? DW'(-lane_in[k]) : DW'(lane_in[k]);
            prod_hi[k]  = PW'(mag[k]) * PW'(INV_GAIN_HI);
            prod_lo[k]  = PW'(mag[k]) * PW'(INV_GAIN_LO);
            total[k]    = SW'(hi_reg[k]) + SW'(lo_reg[k]) + ROUND;
            rounded[k]  = total[k][SW-1:RS];
            clipped[k]  = (rounded[k] > LIM) ? LIM[SAMPLE_WIDTH-1:0]
                                              : rounded[k][SAMPLE_WIDTH-1:0];
            res_next[k] = neg_reg[k] ? -signed'({1'b0, clipped[k]})
                                     : signed'({1'b0, clipped[k]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= in_valid;
            valid_reg     <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            hi_reg[k]  <= prod_hi[k];
            lo_reg[k]  <= prod_lo[k][PW-1:16];
            neg_reg[k] <= lane_in[k][DW-1];
        end
        d_reg <= res_next[0];
        q_reg <= res_next[1];
    end

    assign out_valid = valid_reg;
    assign d_out     = d_reg;
    assign q_out     = q_reg;

    `PT_ASSERT_IMPL(a_d_saturated, clk, rst_n, valid_reg, (d_reg != {1'b1, {SAMPLE_WIDTH{1'b0}}}), "d output beyond saturation limit")
    `PT_ASSERT_IMPL(a_q_saturated, clk, rst_n, valid_reg, (q_reg != {1'b1, {SAMPLE_WIDTH{1'b0}}}), "q output beyond saturation limit")

endmodule

@@ design/park_transform.sv @@
// ----------------------------------------------------------------------------
// park_transform
// Alpha/beta to d/q rotation by a pipelined CORDIC chain.
// Registers from start to done: pre-rotation, each rotation cell, gain stages.
// Throughput: one word per cycle; busy is never raised, the chain is fully
// pipelined with one register stage per micro-rotation cell.
// Each result shows for one cycle with done; the receiver cannot stall.
// Reset clears the valid chain only; no words are in flight after reset.
// ----------------------------------------------------------------------------
module park_transform
    import pt_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int ANGLE_WIDTH     = ANGLE_WIDTH_DEF,
    parameter int ROTATION_STAGES = ROTATION_STAGES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [SAMPLE_WIDTH-1:0] alpha_component,
    input  logic signed [SAMPLE_WIDTH-1:0] beta_component,
    input  logic        [ANGLE_WIDTH-1:0]  rotor_angle,
    output logic                           done,
    output logic signed [SAMPLE_WIDTH:0]   direct_component,
    output logic signed [SAMPLE_WIDTH:0]   quadrature_component
);

    localparam int DW = SAMPLE_WIDTH + GUARD_BITS + 3;
    localparam int NS = (ROTATION_STAGES < MAX_STAGES) ? ROTATION_STAGES : MAX_STAGES;

    logic                         valid_pipe [NS+1];
    logic signed [DW-1:0]         x_pipe     [NS+1];
    logic signed [DW-1:0]         y_pipe     [NS+1];
    logic signed [ANGLE_BITS-1:0] z_pipe     [NS+1];

    assign busy = 1'b0;

    pt_prerot #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ANGLE_WIDTH  (ANGLE_WIDTH)
    ) u_prerot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .alpha     (alpha_component),
        .beta      (beta_component),
        .angle     (rotor_angle),
        .out_valid (valid_pipe[0]),
        .x_out     (x_pipe[0]),
        .y_out     (y_pipe[0]),
        .z_out     (z_pipe[0])
    );

    for (genvar i = 0; i < NS; i++)
    begin : g_cell
        pt_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .STAGE        (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_pipe[i]),
            .x_in      (x_pipe[i]),
            .y_in      (y_pipe[i]),
            .z_in      (z_pipe[i]),
            .out_valid (valid_pipe[i+1]),
            .x_out     (x_pipe[i+1]),
            .y_out     (y_pipe[i+1]),
            .z_out     (z_pipe[i+1])
        );
    end

    pt_gain #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_pipe[NS]),
        .x_in      (x_pipe[NS]),
        .y_in      (y_pipe[NS]),
        .out_valid (done),
        .d_out     (direct_component),
        .q_out     (quadrature_component)
    );

endmodule
